@@ rtl/pf48_pkg.sv @@
// ============================================================================
// pf48_pkg
// Shared types and codes for the 4 by 8 Playfair cipher block.
// ============================================================================
package pf48_pkg;

    // Square geometry: 4 rows of 8 columns, 32 letters.
    localparam int unsigned LetterW = 5;
    localparam int unsigned RowW    = 2;
    localparam int unsigned ColW    = 3;
    localparam int unsigned SqSize  = 32;
    localparam int unsigned FillW   = 6;

    typedef logic [LetterW-1:0] letter_t;
    typedef logic [RowW-1:0]    row_t;
    typedef logic [ColW-1:0]    col_t;

    // Command codes.
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_FINISH = 3'd2;
    localparam logic [2:0] CMD_ENC    = 3'd3;
    localparam logic [2:0] CMD_DEC    = 3'd4;

    // Status codes.
    localparam logic [1:0] STS_DONE    = 2'd0;
    localparam logic [1:0] STS_DUP     = 2'd1;
    localparam logic [1:0] STS_REFUSED = 2'd2;

    // Letter that stands in for a missing or repeated second letter.
    localparam letter_t PAD_LETTER = 5'd28;

    // Cyclic steps within a row (columns) and within a column (rows).
    localparam col_t COL_STEP_ENC = 3'd1;
    localparam col_t COL_STEP_DEC = 3'd7;
    localparam row_t ROW_STEP_ENC = 2'd1;
    localparam row_t ROW_STEP_DEC = 2'd3;

    localparam letter_t LAST_LETTER = 5'd31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_POS,
        ST_DONE
    } state_t;

endpackage

@@ rtl/pf48_req_if.sv @@
// ============================================================================
// pf48_req_if
// Command channel: valid/ready handshake carrying one command word.
// ============================================================================
interface pf48_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [4:0] first_letter;
    logic [4:0] second_letter;
    logic       second_present;

    modport source (
        output valid, cmd, first_letter, second_letter, second_present,
        input  ready
    );

    modport sink (
        input  valid, cmd, first_letter, second_letter, second_present,
        output ready
    );
endinterface

@@ rtl/pf48_res_if.sv @@
// ============================================================================
// pf48_res_if
// Result channel: valid/ready handshake carrying one result word.
// ============================================================================
interface pf48_res_if;
    logic       valid;
    logic       ready;
    logic [4:0] out_first;
    logic [4:0] out_second;
    logic [1:0] status;
    logic       square_ready;

    modport source (
        output valid, out_first, out_second, status, square_ready,
        input  ready
    );

    modport sink (
        input  valid, out_first, out_second, status, square_ready,
        output ready
    );
endinterface

@@ rtl/playfair_4x8_cipher.sv @@
// ============================================================================
// playfair_4x8_cipher
// Playfair cipher on a 4 by 8 square of a 32-letter alphabet, with commands
// that build the square and commands that encrypt or decrypt one pair.
// ============================================================================
// Clear, add key letter and refused commands go straight to the done state;
// encrypt and decrypt first pass the position state, and finish first walks
// the 32 letters in the fill state. A new word is taken the cycle after the
// result register loads, and that load waits while the result channel is
// stalled, so no new word is taken before the last result has been loaded.
// Reset clears the sequencer, fill count, ready flag and placed bits; the two
// memories are not cleared, and their reads are only used once every entry is written.
// ============================================================================
module playfair_4x8_cipher (
    input  logic       clk,
    input  logic       rst_n,
    pf48_req_if.sink   request,
    pf48_res_if.source result
);
    import pf48_pkg::*;

    // Sequencer and square bookkeeping.
    state_t               state_reg, state_next;
    logic [FillW-1:0]     fill_count_reg, fill_count_next;
    logic                 ready_flag_reg, ready_flag_next;
    logic [SqSize-1:0]    placed_reg, placed_next;
    letter_t              walk_reg, walk_next;
    logic                 decrypt_reg, decrypt_next;
    logic                 cipher_reg, cipher_next;
    logic [1:0]           status_reg, status_next;

    // Result register, which parts the sequencer from the result channel.
    logic                 out_valid_reg;
    letter_t              out_first_reg;
    letter_t              out_second_reg;
    logic [1:0]           out_status_reg;
    logic                 out_ready_reg;
    logic                 out_load;

    // Memories: letter at each square position and position of each letter.
    letter_t              sq_mem  [SqSize];
    letter_t              pos_mem [SqSize];
    logic                 wr_en;
    letter_t              wr_pos;
    letter_t              wr_letter;
    letter_t              pos_rd_a_reg, pos_rd_b_reg;
    letter_t              sq_rd_a_reg, sq_rd_b_reg;
    logic                 sq_rd_en;
    letter_t              second_eff;
    letter_t              target_a, target_b;

    // Cipher geometry taken from the two looked-up positions.
    row_t                 row_a, row_b;
    col_t                 col_a, col_b;
    row_t                 row_step;
    col_t                 col_step;

    // When encrypting, a missing second letter or one equal to the first is
    // replaced by the pad letter before its position is looked up.
    always_comb
    begin
        if ((request.cmd == CMD_ENC)
            && (!request.second_present || (request.second_letter == request.first_letter)))
        begin
            second_eff = PAD_LETTER;
        end
        else
        begin
            second_eff = request.second_letter;
        end
    end

    // Target positions. Same row shifts the column, same column shifts the
    // row, and otherwise each letter keeps its row and takes the other column.
    always_comb
    begin
        row_a    = pos_rd_a_reg[LetterW-1:ColW];
        col_a    = pos_rd_a_reg[ColW-1:0];
        row_b    = pos_rd_b_reg[LetterW-1:ColW];
        col_b    = pos_rd_b_reg[ColW-1:0];
        row_step = decrypt_reg ? ROW_STEP_DEC : ROW_STEP_ENC;
        col_step = decrypt_reg ? COL_STEP_DEC : COL_STEP_ENC;
        if (row_a == row_b)
        begin
            target_a = {row_a, col_t'(col_a + col_step)};
            target_b = {row_b, col_t'(col_b + col_step)};
        end
        else if (col_a == col_b)
        begin
            target_a = {row_t'(row_a + row_step), col_a};
            target_b = {row_t'(row_b + row_step), col_b};
        end
        else
        begin
            target_a = {row_a, col_b};
            target_b = {row_b, col_a};
        end
    end

    // Sequencer: state register and bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            ready_flag_reg <= 1'b0;
            placed_reg     <= '0;
            walk_reg       <= '0;
            decrypt_reg    <= 1'b0;
            cipher_reg     <= 1'b0;
            status_reg     <= STS_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            ready_flag_reg <= ready_flag_next;
            placed_reg     <= placed_next;
            walk_reg       <= walk_next;
            decrypt_reg    <= decrypt_next;
            cipher_reg     <= cipher_next;
            status_reg     <= status_next;
        end
    end

    // Next state and control. A word is taken only in the idle state; clear
    // and add key letter finish in the accept cycle itself, the finish walk
    // checks one letter per cycle and places it if it is missing, and a cipher
    // pair does its letter reads in the position state once its two positions are known.
    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        ready_flag_next = ready_flag_reg;
        placed_next     = placed_reg;
        walk_next       = walk_reg;
        decrypt_next    = decrypt_reg;
        cipher_next     = cipher_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_pos          = fill_count_reg[LetterW-1:0];
        wr_letter       = request.first_letter;
        sq_rd_en        = 1'b0;
        out_load        = 1'b0;
        request.ready   = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    cipher_next  = 1'b0;
                    status_next  = STS_DONE;
                    decrypt_next = (request.cmd == CMD_DEC);
                    state_next   = ST_DONE;
                    unique case (request.cmd)
                        CMD_CLEAR:
                        begin
                            placed_next     = '0;
                            fill_count_next = '0;
                            ready_flag_next = 1'b0;
                        end
                        CMD_ADD:
                        begin
                            if (ready_flag_reg)
                            begin
                                status_next = STS_REFUSED;
                            end
                            else if (placed_reg[request.first_letter])
                            begin
                                status_next = STS_DUP;
                            end
                            else
                            begin
                                wr_en                             = 1'b1;
                                placed_next[request.first_letter] = 1'b1;
                                fill_count_next = fill_count_reg + FillW'(1);
                            end
                        end
                        CMD_FINISH:
                        begin
                            if (ready_flag_reg)
                            begin
                                status_next = STS_REFUSED;
                            end
                            else
                            begin
                                walk_next  = '0;
                                state_next = ST_FILL;
                            end
                        end
                        CMD_ENC, CMD_DEC:
                        begin
                            if (!ready_flag_reg)
                            begin
                                status_next = STS_REFUSED;
                            end
                            else
                            begin
                                cipher_next = 1'b1;
                                state_next  = ST_POS;
                            end
                        end
                        default:
                        begin
                            status_next = STS_REFUSED;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                wr_letter = walk_reg;
                if (!placed_reg[walk_reg])
                begin
                    wr_en                 = 1'b1;
                    placed_next[walk_reg] = 1'b1;
                    fill_count_next       = fill_count_reg + FillW'(1);
                end
                if (walk_reg == LAST_LETTER)
                begin
                    ready_flag_next = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    walk_next = walk_reg + LetterW'(1);
                end
            end
            ST_POS:
            begin
                sq_rd_en   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory write port, shared by key letters and the finish walk.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sq_mem[wr_pos]     <= wr_letter;
            pos_mem[wr_letter] <= wr_pos;
        end
    end

    // Position lookups follow the offered word while idle, so both positions
    // are ready the cycle after a cipher pair is accepted.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            pos_rd_a_reg <= pos_mem[request.first_letter];
            pos_rd_b_reg <= pos_mem[second_eff];
        end
    end

    // Letter reads at the two target positions.
    always_ff @(posedge clk)
    begin
        if (sq_rd_en)
        begin
            sq_rd_a_reg <= sq_mem[target_a];
            sq_rd_b_reg <= sq_mem[target_b];
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload. Letters are zero unless a cipher pair was worked.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_first_reg  <= cipher_reg ? sq_rd_a_reg : '0;
            out_second_reg <= cipher_reg ? sq_rd_b_reg : '0;
            out_status_reg <= status_reg;
            out_ready_reg  <= ready_flag_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_first    = out_first_reg;
    assign result.out_second   = out_second_reg;
    assign result.status       = out_status_reg;
    assign result.square_ready = out_ready_reg;

endmodule
